// File: rtl/core/cbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_pkg: shared types and constants of the scrambled cartridge bank switch
// Request structs, register indexes, decode keys and the bit swap helpers.
// ----------------------------------------------------------------------------
package cbs_pkg;

    // Number of 1 KiB pattern bank slots.
    localparam int PATTERN_SLOTS = 8;
    localparam int SLOT_W        = $clog2(PATTERN_SLOTS);

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PRG_BANK_LIMIT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CHR_BANK_LIMIT = 2'd1;

    // Reset values.
    localparam logic [3:0] PRG_LIMIT_RESET = 4'hF;
    localparam logic [7:0] CHR_LIMIT_RESET = 8'hFF;
    localparam logic [3:0] PRG_LOW_RESET   = 4'd0;
    localparam logic [3:0] PRG_HIGH_RESET  = 4'd1;

    // Decode keys: address bits 15:12 followed by address bits 3:0.
    localparam logic [7:0] KEY_PRG_LOW  = 8'h80;
    localparam logic [7:0] KEY_MIRROR   = 8'h88;
    localparam logic [7:0] KEY_PRG_HIGH = 8'hA0;

    // Address bits 15:12 of the pattern register groups.
    localparam logic [3:0] PAGE_A = 4'hA;
    localparam logic [3:0] PAGE_C = 4'hC;
    localparam logic [3:0] PAGE_E = 4'hE;

    // One CPU write request.
    typedef struct packed {
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_in_req;

    // One mapping report.
    typedef struct packed {
        logic [3:0] prg_bank_low_window;
        logic [3:0] prg_bank_high_window;
        logic       mirror_horizontal;
        logic [7:0] chr_bank_0;
        logic [7:0] chr_bank_1;
        logic [7:0] chr_bank_2;
        logic [7:0] chr_bank_3;
        logic [7:0] chr_bank_4;
        logic [7:0] chr_bank_5;
        logic [7:0] chr_bank_6;
        logic [7:0] chr_bank_7;
    } t_out_req;

    // Program bank data has bits 1 and 3 swapped.
    function automatic logic [3:0] swap_bits_1_3(input logic [3:0] d);
        return {d[1], d[2], d[3], d[0]};
    endfunction

    // High nibble pattern data has bits 1 and 2 swapped.
    function automatic logic [3:0] swap_bits_1_2(input logic [3:0] d);
        return {d[3], d[1], d[2], d[0]};
    endfunction

endpackage

// File: rtl/core/cartridge_bank_switch_scrambled.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_switch_scrambled: scrambled cartridge bank switch
// Decodes CPU writes into program, mirroring and pattern bank registers and
// reports the complete mapping after every write.
// ----------------------------------------------------------------------------
// Every accepted write request updates the bank registers at that clock edge
// and loads the resulting mapping into the result register, so a report is
// offered in the cycle after its write. One request is taken in every cycle:
// the input is held off only while the result register is full and the
// downstream side stalls it. A report carries the whole mapping as it stands
// after its own write, independent of later writes. The limit registers clamp
// a bank value that exceeds them by ANDing it with the limit.
module cartridge_bank_switch_scrambled (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  cbs_pkg::t_in_req                i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output cbs_pkg::t_out_req               o_out,
    input  logic                            i_cfg_we,
    input  logic [cbs_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [cbs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import cbs_pkg::*;

    // Configuration registers.
    logic [3:0] r_prg_limit;
    logic [7:0] r_chr_limit;

    // Mapping state.
    logic [3:0] r_prg_low, n_prg_low;
    logic [3:0] r_prg_high, n_prg_high;
    logic       r_mirror, n_mirror;
    logic [7:0] r_chr [PATTERN_SLOTS];
    logic [7:0] n_chr [PATTERN_SLOTS];

    // Result register.
    logic       r_out_valid;
    t_out_req   r_out;
    t_out_req   n_out;

    logic       in_accept;
    logic [7:0] key;
    logic [3:0] page;
    logic [3:0] lo;
    logic       chr_hit;
    logic [SLOT_W-1:0] chr_slot;
    logic [3:0] prg_swapped;
    logic [3:0] prg_value;
    logic [7:0] chr_merged;
    logic [7:0] chr_value;

    // Handshake: take a request whenever the result register can be refilled.
    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_limit <= PRG_LIMIT_RESET;
            r_chr_limit <= CHR_LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_PRG_BANK_LIMIT) begin
                r_prg_limit <= i_cfg_data[3:0];
            end
            if (i_cfg_index == CFG_CHR_BANK_LIMIT) begin
                r_chr_limit <= i_cfg_data[7:0];
            end
        end
    end

    // Address decode on bits 15:12 and 3:0.
    assign page = i_in.bus_address[15:12];
    assign lo   = i_in.bus_address[3:0];
    assign key  = {page, lo};

    always_comb begin
        chr_hit  = 1'b0;
        chr_slot = '0;
        unique case (page)
            PAGE_A: begin
                if (lo[3:2] == 2'b10) begin
                    chr_hit  = 1'b1;
                    chr_slot = SLOT_W'({2'b00, lo[1]});
                end
            end
            PAGE_C: begin
                if (lo[3:2] == 2'b00) begin
                    chr_hit  = 1'b1;
                    chr_slot = SLOT_W'({2'b01, lo[1]});
                end else if (lo[3:2] == 2'b10) begin
                    chr_hit  = 1'b1;
                    chr_slot = SLOT_W'({2'b10, lo[1]});
                end
            end
            PAGE_E: begin
                if (lo[3:2] == 2'b00) begin
                    chr_hit  = 1'b1;
                    chr_slot = SLOT_W'({2'b11, lo[1]});
                end
            end
            default: begin
                chr_hit = 1'b0;
            end
        endcase
    end

    // Descrambled and clamped program bank value.
    assign prg_swapped = swap_bits_1_3(i_in.write_data[3:0]);
    assign prg_value   = (prg_swapped > r_prg_limit) ? (prg_swapped & r_prg_limit)
                                                     : prg_swapped;

    // Nibble merge with the addressed pattern register, then clamp.
    assign chr_merged = lo[0] ? {swap_bits_1_2(i_in.write_data[3:0]), r_chr[chr_slot][3:0]}
                              : {r_chr[chr_slot][7:4], i_in.write_data[3:0]};
    assign chr_value  = (chr_merged > r_chr_limit) ? (chr_merged & r_chr_limit)
                                                   : chr_merged;

    // Next mapping state after this request.
    always_comb begin
        n_prg_low  = r_prg_low;
        n_prg_high = r_prg_high;
        n_mirror   = r_mirror;
        for (int i = 0; i < PATTERN_SLOTS; i++) begin
            n_chr[i] = r_chr[i];
        end
        if (key == KEY_PRG_LOW) begin
            n_prg_low = prg_value;
        end
        if (key == KEY_PRG_HIGH) begin
            n_prg_high = prg_value;
        end
        if (key == KEY_MIRROR) begin
            n_mirror = i_in.write_data[0];
        end
        if (chr_hit) begin
            n_chr[chr_slot] = chr_value;
        end
    end

    // Report built from the updated state.
    always_comb begin
        n_out.prg_bank_low_window  = n_prg_low;
        n_out.prg_bank_high_window = n_prg_high;
        n_out.mirror_horizontal    = n_mirror;
        n_out.chr_bank_0           = n_chr[0];
        n_out.chr_bank_1           = n_chr[1];
        n_out.chr_bank_2           = n_chr[2];
        n_out.chr_bank_3           = n_chr[3];
        n_out.chr_bank_4           = n_chr[4];
        n_out.chr_bank_5           = n_chr[5];
        n_out.chr_bank_6           = n_chr[6];
        n_out.chr_bank_7           = n_chr[7];
    end

    // Mapping state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prg_low  <= PRG_LOW_RESET;
            r_prg_high <= PRG_HIGH_RESET;
            r_mirror   <= 1'b0;
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                r_chr[i] <= 8'(i);
            end
        end else if (in_accept) begin
            r_prg_low  <= n_prg_low;
            r_prg_high <= n_prg_high;
            r_mirror   <= n_mirror;
            for (int i = 0; i < PATTERN_SLOTS; i++) begin
                r_chr[i] <= n_chr[i];
            end
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/core/cbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbs_checker: port level checks of the scrambled cartridge bank switch
// Watches the request channels and the result register behavior.
// ----------------------------------------------------------------------------
module cbs_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input cbs_pkg::t_out_req  o_out
);
    import cbs_pkg::*;

    // A stalled report stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out)))
        else $error("stalled report changed or was dropped");

    // Every accepted write request yields a report in the next cycle.
    a_accept_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted request produced no report");

    // Input is held off only behind a full, stalled result register.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a blocked report");

    // A taken report with no new request leaves the output empty.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && !(i_in_valid && !o_in_stall))
            |=> !o_out_valid)
        else $error("report repeated or invented");

endmodule

bind cartridge_bank_switch_scrambled cbs_checker u_cbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

// File: bench/cartridge_bank_switch_scrambled_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_bank_switch_scrambled_test: bank switch mapping testbench
// Drives CPU write requests into the bank switch and keeps a local copy of
// the program, mirroring and pattern bank registers. Every mapping report
// that comes out is compared field by field with the mapping that this copy
// predicts. Directed decode writes, clamping under several limit settings,
// ignored register indexes, a long downstream hold-off and random traffic
// are run in turn, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module cartridge_bank_switch_scrambled_test;
    import cbs_pkg::*;

    // Rows of address bits 3:2 that hold pattern register decodes.
    localparam logic [1:0] LOW_ROW  = 2'b00;
    localparam logic [1:0] HIGH_ROW = 2'b10;

    // Register indexes that the block has no register for.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_3 = 2'd3;

    // Number of decodable write targets: two program banks, mirroring and
    // sixteen pattern nibbles.
    localparam int NUM_TARGETS = 19;

    localparam int DRAIN_CYCLES = 4;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_req                i_in;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_req               o_out;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    cartridge_bank_switch_scrambled dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Local copy of the mapping state and the limit registers.
    logic [3:0] prg_limit_copy;
    logic [7:0] chr_limit_copy;
    logic [3:0] prg_bank_copy [2];
    logic       mirror_copy;
    logic [7:0] chr_bank_copy [PATTERN_SLOTS];

    // Mapping reports still owed by the block, oldest first.
    t_out_req pending_mappings[$];

    int errors          = 0;
    int writes_sent     = 0;
    int reports_checked = 0;
    int limit_writes    = 0;
    int hold_offs       = 0;

    // Sender pacing and receiver stall controls.
    bit tx_gaps_en     = 0;
    int tx_burst_left  = 0;
    bit rx_stall_en    = 0;
    int rx_run_left    = 0;
    bit rx_stall_state = 0;
    int hold_off_left  = 0;

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Overall time limit.
    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // Clamp a bank number to its limit by masking when it is above it.
    function automatic logic [7:0] clamp_to_limit(input logic [7:0] v, input logic [7:0] lim);
        return (v > lim) ? (v & lim) : v;
    endfunction

    // Merge one nibble into a pattern bank register, then clamp the result.
    function automatic void store_pattern_nibble(input int slot, input bit high_half,
                                                 input logic [3:0] d);
        logic [7:0] merged;
        if (high_half) begin
            merged = {d[3], d[1], d[2], d[0], chr_bank_copy[slot][3:0]};
        end else begin
            merged = {chr_bank_copy[slot][7:4], d};
        end
        chr_bank_copy[slot] = clamp_to_limit(merged, chr_limit_copy);
    endfunction

    // Apply one CPU write to the local state and return the mapping after it.
    function automatic t_out_req apply_cpu_write(input t_in_req req);
        logic [7:0] key;
        logic [3:0] lo;
        logic [7:0] bank;
        int         slot;
        t_out_req   rpt;
        key  = {req.bus_address[15:12], req.bus_address[3:0]};
        lo   = key[3:0];
        bank = clamp_to_limit({4'h0, req.write_data[1], req.write_data[2],
                               req.write_data[3], req.write_data[0]},
                              {4'h0, prg_limit_copy});
        slot = -1;
        if (key == KEY_PRG_LOW) begin
            prg_bank_copy[0] = bank[3:0];
        end else if (key == KEY_PRG_HIGH) begin
            prg_bank_copy[1] = bank[3:0];
        end else if (key == KEY_MIRROR) begin
            mirror_copy = req.write_data[0];
        end else if (key[7:4] == PAGE_A && lo[3:2] == HIGH_ROW) begin
            slot = int'(lo[1]);
        end else if (key[7:4] == PAGE_C && lo[3:2] == LOW_ROW) begin
            slot = 2 + int'(lo[1]);
        end else if (key[7:4] == PAGE_C && lo[3:2] == HIGH_ROW) begin
            slot = 4 + int'(lo[1]);
        end else if (key[7:4] == PAGE_E && lo[3:2] == LOW_ROW) begin
            slot = 6 + int'(lo[1]);
        end
        if (slot >= 0) begin
            store_pattern_nibble(slot, lo[0], req.write_data[3:0]);
        end
        rpt.prg_bank_low_window  = prg_bank_copy[0];
        rpt.prg_bank_high_window = prg_bank_copy[1];
        rpt.mirror_horizontal    = mirror_copy;
        rpt.chr_bank_0           = chr_bank_copy[0];
        rpt.chr_bank_1           = chr_bank_copy[1];
        rpt.chr_bank_2           = chr_bank_copy[2];
        rpt.chr_bank_3           = chr_bank_copy[3];
        rpt.chr_bank_4           = chr_bank_copy[4];
        rpt.chr_bank_5           = chr_bank_copy[5];
        rpt.chr_bank_6           = chr_bank_copy[6];
        rpt.chr_bank_7           = chr_bank_copy[7];
        return rpt;
    endfunction

    // Address of one write target, with the undecoded bits 11:4 at zero.
    function automatic logic [15:0] target_address(input int sel);
        logic [7:0] key;
        int         k;
        int         slot;
        if (sel == 0) begin
            key = KEY_PRG_LOW;
        end else if (sel == 1) begin
            key = KEY_PRG_HIGH;
        end else if (sel == 2) begin
            key = KEY_MIRROR;
        end else begin
            k    = sel - 3;
            slot = k / 2;
            key[7:4] = (slot < 2) ? PAGE_A : (slot < 6) ? PAGE_C : PAGE_E;
            key[3:0] = {(slot < 2 || slot == 4 || slot == 5), 1'b0, slot[0], k[0]};
        end
        return {key[7:4], 8'h00, key[3:0]};
    endfunction

    // Mostly decoded targets with random filler bits, some fully random.
    function automatic t_in_req random_cpu_write();
        t_in_req req;
        if ($urandom_range(0, 4) == 0) begin
            req.bus_address = 16'($urandom);
        end else begin
            req.bus_address = target_address($urandom_range(0, NUM_TARGETS - 1));
            req.bus_address[11:4] = 8'($urandom);
        end
        req.write_data = 8'($urandom);
        return req;
    endfunction

    function automatic t_in_req make_write(input logic [15:0] addr, input logic [7:0] data);
        t_in_req req;
        req.bus_address = addr;
        req.write_data  = data;
        return req;
    endfunction

    // State after reset.
    task automatic reset_mapping_copy();
        prg_limit_copy   = PRG_LIMIT_RESET;
        chr_limit_copy   = CHR_LIMIT_RESET;
        prg_bank_copy[0] = PRG_LOW_RESET;
        prg_bank_copy[1] = PRG_HIGH_RESET;
        mirror_copy      = 1'b0;
        for (int i = 0; i < PATTERN_SLOTS; i++) begin
            chr_bank_copy[i] = 8'(i);
        end
    endtask

    // Bursts of random length separated by random gaps.
    task automatic pace_sender();
        if (tx_gaps_en) begin
            if (tx_burst_left > 0) begin
                tx_burst_left--;
            end else begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                tx_burst_left = $urandom_range(0, 24);
            end
        end
    endtask

    // Offer one write request and hold it until it is taken.
    task automatic send_cpu_write(input t_in_req req);
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        pending_mappings.push_back(apply_cpu_write(req));
        writes_sent++;
        pace_sender();
    endtask

    task automatic send_random_writes(input int count);
        for (int n = 0; n < count; n++) begin
            send_cpu_write(random_cpu_write());
        end
    endtask

    // Stop offering requests until every report has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_mappings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Write one limit register while the block is idle.
    task automatic write_limit(input logic [CFG_INDEX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_PRG_BANK_LIMIT) begin
            prg_limit_copy = data[3:0];
        end else if (idx == CFG_CHR_BANK_LIMIT) begin
            chr_limit_copy = data;
        end
        limit_writes++;
    endtask

    task automatic set_limits(input logic [3:0] prg_lim, input logic [7:0] chr_lim);
        // Upper bits of the program limit data are junk and must be dropped.
        write_limit(CFG_PRG_BANK_LIMIT, {4'($urandom), prg_lim});
        write_limit(CFG_CHR_BANK_LIMIT, chr_lim);
    endtask

    // Every decode target at least once, plus undecoded writes at both address extremes.
    task automatic test_directed_decode();
        send_cpu_write(make_write(16'h0000, 8'hFF));
        send_cpu_write(make_write(target_address(0), 8'hFF));
        send_cpu_write(make_write(target_address(0), 8'h02));
        send_cpu_write(make_write(target_address(1), 8'h08));
        send_cpu_write(make_write(target_address(1), 8'hF0));
        send_cpu_write(make_write(target_address(2), 8'hFF));
        send_cpu_write(make_write(target_address(2), 8'hFE));
        for (int k = 0; k < 16; k++) begin
            send_cpu_write(make_write(target_address(3 + k), 8'(k * 37 + 5)));
        end
        send_cpu_write(make_write(16'hFFFF, 8'h00));
        wait_drained();
    endtask

    // Banks above their limit, with a middle setting and with both limits at zero.
    task automatic test_bank_clamp();
        set_limits(4'd5, 8'h3C);
        send_random_writes(60);
        set_limits(4'd0, 8'h00);
        send_random_writes(40);
        set_limits(PRG_LIMIT_RESET, CHR_LIMIT_RESET);
    endtask

    // Writes to indexes without a register leave the limits alone.
    task automatic test_unused_index();
        write_limit(CFG_UNUSED_2, 8'h00);
        write_limit(CFG_UNUSED_3, 8'h00);
        send_random_writes(20);
        wait_drained();
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure();
        tx_gaps_en    = 0;
        hold_off_left = 300;
        hold_offs++;
        send_random_writes(60);
        wait_drained();
        tx_gaps_en = 1;
    endtask

    // Random traffic under several limit settings.
    task automatic test_random_traffic();
        set_limits(4'($urandom), 8'($urandom));
        send_random_writes(300);
        set_limits(PRG_LIMIT_RESET, CHR_LIMIT_RESET);
        send_random_writes(300);
        // A stretch with neither side idling.
        tx_gaps_en  = 0;
        rx_stall_en = 0;
        send_random_writes(100);
        tx_gaps_en  = 1;
        rx_stall_en = 1;
        set_limits(4'($urandom_range(1, 14)), 8'($urandom_range(1, 254)));
        send_random_writes(300);
        set_limits(4'($urandom), 8'($urandom));
        send_random_writes(300);
        wait_drained();
    endtask

    // Receiver stall: alternating runs, occasional long clean stretches and a
    // forced hold-off when one is requested.
    always @(posedge i_clk) begin
        if (hold_off_left > 0) begin
            i_out_stall <= 1'b1;
            hold_off_left--;
        end else if (!rx_stall_en) begin
            i_out_stall <= 1'b0;
        end else begin
            if (rx_run_left == 0) begin
                rx_stall_state = !rx_stall_state;
                if (rx_stall_state) begin
                    rx_run_left = $urandom_range(1, 5);
                end else if ($urandom_range(0, 7) == 0) begin
                    rx_run_left = $urandom_range(30, 60);
                end else begin
                    rx_run_left = $urandom_range(1, 12);
                end
            end
            rx_run_left--;
            i_out_stall <= rx_stall_state;
        end
    end

    // Report one field that differs from its prediction.
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endtask

    // Compare every accepted report with the oldest prediction.
    always @(posedge i_clk) begin
        t_out_req want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_mappings.size() == 0) begin
                errors++;
                $display("%0t: report with no write outstanding, expected none, actual %h",
                         $time, o_out);
            end else begin
                want = pending_mappings.pop_front();
                reports_checked++;
                check_field("prg_bank_low_window", 8'(want.prg_bank_low_window),
                            8'(o_out.prg_bank_low_window));
                check_field("prg_bank_high_window", 8'(want.prg_bank_high_window),
                            8'(o_out.prg_bank_high_window));
                check_field("mirror_horizontal", 8'(want.mirror_horizontal),
                            8'(o_out.mirror_horizontal));
                check_field("chr_bank_0", want.chr_bank_0, o_out.chr_bank_0);
                check_field("chr_bank_1", want.chr_bank_1, o_out.chr_bank_1);
                check_field("chr_bank_2", want.chr_bank_2, o_out.chr_bank_2);
                check_field("chr_bank_3", want.chr_bank_3, o_out.chr_bank_3);
                check_field("chr_bank_4", want.chr_bank_4, o_out.chr_bank_4);
                check_field("chr_bank_5", want.chr_bank_5, o_out.chr_bank_5);
                check_field("chr_bank_6", want.chr_bank_6, o_out.chr_bank_6);
                check_field("chr_bank_7", want.chr_bank_7, o_out.chr_bank_7);
            end
        end
    end

    // Reset, then run the tests in turn.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        i_out_stall <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        reset_mapping_copy();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_gaps_en  = 1;
        rx_stall_en = 1;
        test_directed_decode();
        test_bank_clamp();
        test_unused_index();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Covered %0d CPU writes and %0d mapping reports, %0d limit writes,",
                 writes_sent, reports_checked, limit_writes);
        $display("%0d long downstream hold-off(s); %0d mismatch(es) seen.", hold_offs, errors);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
